### hdl/sllc_pkg.sv
// Shared types and constants for the linked list cursor manager.
package sllc_pkg;

  localparam int unsigned POOL_NODES_DEF = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;

  typedef enum logic [3:0] {
    CMD_CLEAR     = 4'd0,
    CMD_INS_HEAD  = 4'd1,
    CMD_CUR_HEAD  = 4'd2,
    CMD_DEL_HEAD  = 4'd3,
    CMD_DEL_AFTER = 4'd4,
    CMD_INS_AFTER = 4'd5,
    CMD_OVERWRITE = 4'd6,
    CMD_ADVANCE   = 4'd7,
    CMD_QUERY     = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC,
    ST_STEP2,
    ST_STEP3,
    ST_STEP4,
    ST_VALRD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic               status;
    logic               list_nonempty;
    logic signed [31:0] head_value;
    logic               cursor_active;
    logic signed [31:0] cursor_value;
  } out_t;

endpackage

### hdl/sllc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sllc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sllc_ctrl.sv
// Command sequencer: list pointers, free list and node memory accesses.
module sllc_ctrl #(
  parameter int unsigned POOL_NODES = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  sllc_pkg::in_t                   cmd_data_i,
  output logic                            busy_o,
  output logic                            link_we_o,
  output logic [$clog2(POOL_NODES)-1:0]   link_waddr_o,
  output logic [$clog2(POOL_NODES+1)-1:0] link_wdata_o,
  output logic [$clog2(POOL_NODES)-1:0]   link_raddr_o,
  input  logic [$clog2(POOL_NODES+1)-1:0] link_rdata_i,
  output logic                            val_we_o,
  output logic [$clog2(POOL_NODES)-1:0]   val_waddr_o,
  output logic [VALUE_BITS-1:0]           val_wdata_o,
  output logic [$clog2(POOL_NODES)-1:0]   val_raddr_o,
  input  logic [VALUE_BITS-1:0]           val_rdata_i,
  output logic                            res_valid_o,
  input  logic                            res_take_i,
  output sllc_pkg::out_t                  res_data_o
);

  import sllc_pkg::*;

  localparam int unsigned AW    = $clog2(POOL_NODES);
  localparam int unsigned IDX_W = $clog2(POOL_NODES + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_NODES);

  state_e state_q, state_d;
  logic [3:0] cmd_q, cmd_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] free_q, free_d;
  logic [IDX_W-1:0] fresh_q, fresh_d;
  logic [IDX_W-1:0] node_q, node_d;
  logic signed [VALUE_BITS-1:0] head_val_q, head_val_d;
  logic signed [VALUE_BITS-1:0] cur_val_q, cur_val_d;
  logic status_q, status_d;

  logic head_ok, cur_ok, free_ok, rd_ok;
  logic alloc_ok;
  logic [IDX_W-1:0] alloc_idx;
  logic [IDX_W-1:0] rd_norm;
  logic signed [63:0] in_wide, head_wide, cur_wide;

  assign head_ok = head_q < NIL;
  assign cur_ok  = cur_q < NIL;
  assign free_ok = free_q < NIL;
  assign rd_ok   = link_rdata_i < NIL;
  assign rd_norm = rd_ok ? link_rdata_i : NIL;

  // recycled nodes first, then the high-water counter
  assign alloc_ok  = free_ok || (fresh_q < NIL);
  assign alloc_idx = free_ok ? free_q : fresh_q;

  assign in_wide   = 64'(cmd_data_i.value);
  assign head_wide = 64'(head_val_q);
  assign cur_wide  = 64'(cur_val_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_INS_HEAD:  state_d = ST_ALLOC;
          CMD_DEL_HEAD:  state_d = head_ok ? ST_STEP2 : ST_RESP;
          CMD_DEL_AFTER,
          CMD_ADVANCE:   state_d = cur_ok ? ST_STEP2 : ST_RESP;
          CMD_INS_AFTER: state_d = cur_ok ? ST_ALLOC : ST_RESP;
          default:       state_d = ST_RESP;
        endcase
      end
      ST_ALLOC: begin
        state_d = (alloc_ok && cmd_q == CMD_INS_AFTER) ? ST_STEP3 : ST_RESP;
      end
      ST_STEP2: begin
        case (cmd_q)
          CMD_DEL_HEAD,
          CMD_ADVANCE:   state_d = rd_ok ? ST_VALRD : ST_RESP;
          CMD_DEL_AFTER: state_d = rd_ok ? ST_STEP3 : ST_RESP;
          default:       state_d = ST_RESP;
        endcase
      end
      ST_STEP3: state_d = ST_STEP4;
      ST_STEP4: state_d = ST_RESP;
      ST_VALRD: state_d = ST_RESP;
      ST_RESP: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d        = cmd_q;
    val_d        = val_q;
    head_d       = head_q;
    cur_d        = cur_q;
    free_d       = free_q;
    fresh_d      = fresh_q;
    node_d       = node_q;
    head_val_d   = head_val_q;
    cur_val_d    = cur_val_q;
    status_d     = status_q;
    link_we_o    = 1'b0;
    link_waddr_o = cur_q[AW-1:0];
    link_wdata_o = link_rdata_i;
    link_raddr_o = cur_q[AW-1:0];
    val_we_o     = 1'b0;
    val_waddr_o  = alloc_idx[AW-1:0];
    val_wdata_o  = val_q;
    val_raddr_o  = link_rdata_i[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_data_i.cmd;
          val_d    = in_wide[VALUE_BITS-1:0];
          status_d = 1'b0;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_CLEAR: begin
            head_d  = NIL;
            cur_d   = NIL;
            free_d  = NIL;
            fresh_d = '0;
          end
          CMD_INS_HEAD,
          CMD_INS_AFTER: link_raddr_o = free_q[AW-1:0];
          CMD_CUR_HEAD: begin
            cur_d     = head_q;
            cur_val_d = head_val_q;
          end
          CMD_DEL_HEAD: link_raddr_o = head_q[AW-1:0];
          CMD_OVERWRITE: begin
            if (cur_ok) begin
              val_we_o    = 1'b1;
              val_waddr_o = cur_q[AW-1:0];
              cur_val_d   = val_q;
              if (cur_q == head_q) head_val_d = val_q;
            end
          end
          default: ;
        endcase
      end
      ST_ALLOC: begin
        if (!alloc_ok) begin
          status_d = 1'b1;
        end else begin
          node_d   = alloc_idx;
          val_we_o = 1'b1;
          if (free_ok) free_d = link_rdata_i;
          else         fresh_d = fresh_q + IDX_W'(1);
          if (cmd_q == CMD_INS_HEAD) begin
            link_we_o    = 1'b1;
            link_waddr_o = alloc_idx[AW-1:0];
            link_wdata_o = head_q;
            head_d       = alloc_idx;
            head_val_d   = val_q;
          end
        end
      end
      ST_STEP2: begin
        case (cmd_q)
          CMD_DEL_HEAD: begin
            head_d       = rd_norm;
            link_we_o    = 1'b1;
            link_waddr_o = head_q[AW-1:0];
            link_wdata_o = free_q;
            free_d       = head_q;
            if (cur_q == head_q) cur_d = NIL;
          end
          CMD_DEL_AFTER: begin
            node_d       = link_rdata_i;
            link_raddr_o = link_rdata_i[AW-1:0];
          end
          CMD_ADVANCE: cur_d = rd_norm;
          default: ;
        endcase
      end
      ST_STEP3: begin
        // splice: cursor skips the victim, or new node takes cursor's successor
        link_we_o = 1'b1;
        if (cmd_q != CMD_DEL_AFTER) link_waddr_o = node_q[AW-1:0];
      end
      ST_STEP4: begin
        link_we_o = 1'b1;
        if (cmd_q == CMD_DEL_AFTER) begin
          link_waddr_o = node_q[AW-1:0];
          link_wdata_o = free_q;
          free_d       = node_q;
        end else begin
          link_wdata_o = node_q;
        end
      end
      ST_VALRD: begin
        if (cmd_q == CMD_DEL_HEAD) head_val_d = val_rdata_i;
        else                       cur_val_d  = val_rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= NIL;
      cur_q    <= NIL;
      free_q   <= NIL;
      fresh_q  <= '0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cur_q    <= cur_d;
      free_q   <= free_d;
      fresh_q  <= fresh_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    node_q     <= node_d;
    head_val_q <= head_val_d;
    cur_val_q  <= cur_val_d;
  end

  assign busy_o      = state_q != ST_IDLE;
  assign res_valid_o = state_q == ST_RESP;

  always_comb begin
    res_data_o.status        = status_q;
    res_data_o.list_nonempty = head_ok;
    res_data_o.head_value    = head_ok ? head_wide[31:0] : '0;
    res_data_o.cursor_active = cur_ok;
    res_data_o.cursor_value  = cur_ok ? cur_wide[31:0] : '0;
  end

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= NIL)
    else $error("high-water count beyond pool size");

  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_ok |-> head_ok)
    else $error("cursor active on an empty list");

  a_free_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_ok |-> free_q != head_q)
    else $error("list head also heads the free list");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("command started while sequencer busy");

endmodule

### hdl/singly_linked_list_cursor_manager.sv
// Top level: node memories, command sequencer and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------
//  in      | input     | in_valid_i / in_stall_o  | in_data_i (in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//
// Each command passes EXEC and RESP; insert head also passes ALLOC, delete
// head and advance may pass STEP2 and VALRD, insert after ALLOC, STEP3 and
// STEP4, delete after STEP2, STEP3 and STEP4; the single read port of the
// link memory sets these steps. Reset clears pointers and counters only; the
// node memories need no clearing. A held result in the output register does
// not stop the next command from being taken, but its result waits there.
module singly_linked_list_cursor_manager #(
  parameter int unsigned POOL_NODES = sllc_pkg::POOL_NODES_DEF,
  parameter int unsigned VALUE_BITS = sllc_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sllc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sllc_pkg::out_t out_data_o
);

  import sllc_pkg::*;

  localparam int unsigned AW    = $clog2(POOL_NODES);
  localparam int unsigned IDX_W = $clog2(POOL_NODES + 1);

  logic             busy;
  logic             start;
  logic             link_we;
  logic [AW-1:0]    link_waddr, link_raddr;
  logic [IDX_W-1:0] link_wdata, link_rdata;
  logic             val_we;
  logic [AW-1:0]    val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic             res_valid, res_take;
  out_t             res_data;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q;

  assign start      = in_valid_i && !busy;
  assign in_stall_o = busy;

  sllc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  sllc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (POOL_NODES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  sllc_ctrl #(
    .POOL_NODES (POOL_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .cmd_data_i   (in_data_i),
    .busy_o       (busy),
    .link_we_o    (link_we),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .link_raddr_o (link_raddr),
    .link_rdata_i (link_rdata),
    .val_we_o     (val_we),
    .val_waddr_o  (val_waddr),
    .val_wdata_o  (val_wdata),
    .val_raddr_o  (val_raddr),
    .val_rdata_i  (val_rdata),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_data_o   (res_data)
  );

  // output register frees up when empty or being taken this cycle
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### test/tb_singly_linked_list_cursor_manager.sv
// Self-checking testbench for the linked list cursor manager: directed, exhaustion, stall, random.
module tb_singly_linked_list_cursor_manager;
  import sllc_pkg::*;

  localparam int          NODES       = 256;
  localparam logic [8:0]  NIL         = 9'(NODES);
  localparam int          RANDOM_CMDS = 1350;
  localparam int          HOLD_CYCLES = 400;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          TAIL_CYCLES = 20;
  localparam logic [3:0]  CMD_SPARE   = CMD_QUERY + 4'd1;  // first unused code

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  singly_linked_list_cursor_manager dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the node pool and its pointers
  logic signed [31:0] lst_val [NODES];
  logic [8:0]         lst_nxt [NODES];
  logic [8:0]         lst_head = NIL;
  logic [8:0]         lst_cur = NIL;
  logic [8:0]         lst_free = NIL;
  logic [8:0]         lst_fresh = '0;

  out_t list_view_q[$];
  int   errors = 0;
  int   results_checked = 0;
  int   refusals = 0;
  int   cmd_seen [16];
  int   burst_left = 0;
  int   hold_requests = 0;
  int   idle_cycles = 0;

  function automatic logic [8:0] grab_slot();
    logic [8:0] n;
    if (lst_free != NIL) begin
      n = lst_free;
      lst_free = lst_nxt[n];
    end else if (lst_fresh < NIL) begin
      n = lst_fresh;
      lst_fresh = lst_fresh + 9'd1;
    end else begin
      n = NIL;
    end
    return n;
  endfunction

  function automatic void release_slot(input logic [8:0] n);
    lst_nxt[n] = lst_free;
    lst_free = n;
  endfunction

  function automatic out_t apply_list_cmd(input logic [3:0] c, input logic signed [31:0] v);
    out_t       r;
    logic [8:0] n;
    logic [8:0] victim;
    r = '0;
    case (c)
      CMD_CLEAR: begin
        lst_head = NIL;
        lst_cur = NIL;
        lst_free = NIL;
        lst_fresh = '0;
      end
      CMD_INS_HEAD: begin
        n = grab_slot();
        if (n == NIL) begin
          r.status = 1'b1;
        end else begin
          lst_val[n] = v;
          lst_nxt[n] = lst_head;
          lst_head = n;
        end
      end
      CMD_CUR_HEAD: lst_cur = lst_head;
      CMD_DEL_HEAD: begin
        if (lst_head != NIL) begin
          victim = lst_head;
          if (lst_cur == victim) lst_cur = NIL;
          lst_head = lst_nxt[victim];
          release_slot(victim);
        end
      end
      CMD_DEL_AFTER: begin
        if (lst_cur != NIL) begin
          victim = lst_nxt[lst_cur];
          if (victim != NIL) begin
            lst_nxt[lst_cur] = lst_nxt[victim];
            release_slot(victim);
          end
        end
      end
      CMD_INS_AFTER: begin
        if (lst_cur != NIL) begin
          n = grab_slot();
          if (n == NIL) begin
            r.status = 1'b1;
          end else begin
            lst_val[n] = v;
            lst_nxt[n] = lst_nxt[lst_cur];
            lst_nxt[lst_cur] = n;
          end
        end
      end
      CMD_OVERWRITE: if (lst_cur != NIL) lst_val[lst_cur] = v;
      CMD_ADVANCE: if (lst_cur != NIL) lst_cur = lst_nxt[lst_cur];
      default: ;
    endcase
    r.list_nonempty = (lst_head != NIL);
    r.head_value    = (lst_head != NIL) ? lst_val[lst_head] : '0;
    r.cursor_active = (lst_cur != NIL);
    r.cursor_value  = (lst_cur != NIL) ? lst_val[lst_cur] : '0;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Weighted command pick; slot order: clear, ins head, cur head, del head,
  // del after, ins after, overwrite, advance, query, unused code
  function automatic logic [3:0] pick_cmd(input int profile);
    int w [10];
    int r;
    int acc;
    case (profile)
      0: w = '{1, 35, 8, 4, 4, 25, 6, 12, 2, 3};   // grow
      1: w = '{1, 5, 15, 5, 10, 10, 12, 35, 4, 3}; // walk
      2: w = '{1, 6, 12, 30, 25, 4, 3, 15, 2, 2};  // shrink
      default: return 4'($urandom_range(0, 15));
    endcase
    r = $urandom_range(0, 99);
    acc = 0;
    for (int k = 0; k < 9; k++) begin
      acc += w[k];
      if (r < acc) return 4'(k);
    end
    return CMD_SPARE + 4'($urandom_range(0, 6));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(input logic [3:0] c, input logic signed [31:0] v);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: c, value: v};
    do @(posedge clk_i); while (in_stall_o);
    list_view_q.push_back(apply_list_cmd(c, v));
    if (list_view_q[$].status) refusals++;
    cmd_seen[c]++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Sender stops and waits for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (list_view_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_CUR_HEAD, '0);            // empty list
    send_cmd(CMD_DEL_HEAD, '0);            // empty list
    send_cmd(CMD_DEL_AFTER, '0);           // cursor inactive
    send_cmd(CMD_INS_AFTER, 32'sh7fffffff);
    send_cmd(CMD_OVERWRITE, -32'sd1);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_INS_HEAD, 32'sh7fffffff);
    send_cmd(CMD_INS_HEAD, 32'sh80000000);
    send_cmd(CMD_CUR_HEAD, '0);
    send_cmd(CMD_OVERWRITE, '0);
    send_cmd(CMD_INS_AFTER, -32'sd1);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_DEL_AFTER, '0);           // cursor on last node
    send_cmd(CMD_ADVANCE, '0);             // falls off the end
    send_cmd(CMD_CUR_HEAD, '0);
    send_cmd(CMD_DEL_HEAD, '0);            // cursor sat on the head
    send_cmd(CMD_SPARE + 4'd6, 32'sh55555555);
    send_cmd(CMD_SPARE, 32'shaaaaaaaa);
    send_cmd(CMD_CUR_HEAD, '0);
    send_cmd(CMD_DEL_AFTER, '0);
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_INS_HEAD, 32'sh5555aaaa);
    drain();
  endtask

  task automatic test_pool_exhaustion();
    send_cmd(CMD_CLEAR, '0);
    for (int k = 0; k < NODES; k++) begin
      send_cmd(CMD_INS_HEAD, rand_value());
      if ($urandom_range(0, 9) == 0) send_cmd(CMD_CUR_HEAD, '0);
      if ($urandom_range(0, 9) == 0) send_cmd(CMD_ADVANCE, '0);
    end
    send_cmd(CMD_INS_HEAD, rand_value());  // refused
    send_cmd(CMD_CUR_HEAD, '0);
    send_cmd(CMD_INS_AFTER, rand_value()); // refused
    send_cmd(CMD_DEL_HEAD, '0);
    send_cmd(CMD_CUR_HEAD, '0);
    send_cmd(CMD_INS_AFTER, rand_value()); // recycled node
    send_cmd(CMD_INS_AFTER, rand_value()); // refused again
    send_cmd(CMD_DEL_AFTER, '0);
    send_cmd(CMD_DEL_AFTER, '0);
    send_cmd(CMD_INS_HEAD, rand_value());
    send_cmd(CMD_INS_HEAD, rand_value());
    send_cmd(CMD_INS_HEAD, rand_value());  // refused
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_INS_HEAD, rand_value());  // high-water restarts at zero
    drain();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    burst_left = 60;
    for (int k = 0; k < 60; k++) send_cmd(pick_cmd(0), rand_value());
    drain();
  endtask

  task automatic test_random();
    int sent;
    int seg_len;
    int profile;
    sent = 0;
    while (sent < RANDOM_CMDS) begin
      seg_len = $urandom_range(20, 120);
      profile = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) send_cmd(CMD_CLEAR, '0);
      for (int k = 0; k < seg_len; k++) begin
        send_cmd(pick_cmd(profile), rand_value());
        sent++;
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
  endtask

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    int seg_left;
    int mode;
    int phase;
    hold_seen = 0;
    hold_left = 0;
    seg_left = 0;
    mode = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        phase++;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (list_view_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = list_view_q.pop_front();
        results_checked++;
        if (out_data_o.status !== want.status
            || out_data_o.list_nonempty !== want.list_nonempty
            || out_data_o.head_value !== want.head_value
            || out_data_o.cursor_active !== want.cursor_active
            || out_data_o.cursor_value !== want.cursor_value) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: exp %b %b %h %b %h, got %b %b %h %b %h",
                     results_checked, want.status, want.list_nonempty, want.head_value,
                     want.cursor_active, want.cursor_value, out_data_o.status,
                     out_data_o.list_nonempty, out_data_o.head_value,
                     out_data_o.cursor_active, out_data_o.cursor_value);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, list_view_q.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (cmd_seen[k]) cmd_seen[k] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_pool_exhaustion();
    test_backpressure();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (list_view_q.size() != 0) begin
      errors++;
      $display("%0d results never arrived", list_view_q.size());
    end
    $display("covered: %0d results checked, %0d pool-exhausted refusals, %0d unused codes",
             results_checked, refusals,
             cmd_seen[9] + cmd_seen[10] + cmd_seen[11] + cmd_seen[12] + cmd_seen[13]
             + cmd_seen[14] + cmd_seen[15]);
    $display("cmds: clr %0d insh %0d curh %0d delh %0d dela %0d insa %0d ovw %0d adv %0d q %0d",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4], cmd_seen[5],
             cmd_seen[6], cmd_seen[7], cmd_seen[8]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/sllc_pkg.sv
hdl/sllc_ram.sv
hdl/sllc_ctrl.sv
hdl/singly_linked_list_cursor_manager.sv
test/tb_singly_linked_list_cursor_manager.sv
